// ===== hdl/fragment_gap_tracker_macros.svh =====
// assertion macros for the fragment gap tracker
// used by fragment_gap_tracker.sv, no other dependencies
`ifndef FRAGMENT_GAP_TRACKER_MACROS_SVH
`define FRAGMENT_GAP_TRACKER_MACROS_SVH

// condition implies expectation in the same cycle
`define FGT_ASSERT_NOW(name, cond, implied, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (implied)) \
      else $error(msg);

// condition implies expectation in the following cycle
`define FGT_ASSERT_NEXT(name, cond, implied, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (implied)) \
      else $error(msg);

`endif

// ===== hdl/fgt_pkg.sv =====
// shared types, constants and helpers of the fragment gap tracker
// no dependencies
`default_nettype none

package fgt_pkg;

   localparam int OffsetBits = 32;
   localparam int EndBits    = OffsetBits + 1;
   localparam int CountBits  = 5;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_REQUIRES = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  opcode;
      logic [OffsetBits-1:0]   frag_offset;
      logic [OffsetBits-1:0]   frag_length;
      logic [OffsetBits-1:0]   total_length;
      logic [OffsetBits-1:0]   query_start;
      logic [OffsetBits-1:0]   query_end;
   } req_item_type;

   typedef struct packed {
      logic                    answer;
      logic                    status;
      logic [CountBits-1:0]    entry_count;
   } rsp_item_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                    insert;
      logic [OffsetBits-1:0]   offset;
      logic [EndBits-1:0]      end_pos;
      logic [EndBits-1:0]      total;
      logic [EndBits-1:0]      query_start;
      logic [EndBits-1:0]      query_end;
   } cmd_type;

   // handed from one cell to the next
   typedef struct packed {
      logic                    gt;
      logic [OffsetBits-1:0]   offset;
      logic [EndBits-1:0]      end_pos;
   } link_type;

   typedef struct packed {
      logic                    gap_hit;
      logic                    tile_bad;
   } flag_type;

   function automatic logic strictly_between(input logic [EndBits-1:0] lo,
                                             input logic [EndBits-1:0] x,
                                             input logic [EndBits-1:0] hi);
      strictly_between = (lo < x) && (x < hi);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/fragment_gap_tracker.sv =====
// Fragment gap tracker. An item is accepted while start is high and busy is low,
// and then goes through an execute cycle with busy high, in which the whole
// row of cells shifts for an insert, a clear resets the count, or each fragment
// is compared against its neighbor, with the per-cell flags OR-reduced across the
// row. The result is strobed on rsp_strobe for the one cycle after execute and
// must be taken then: the receiver cannot stall. A new item may be accepted in
// that same cycle, but not while the last item is still executing. Busy is also
// high while reset is asserted.
// depends on fgt_pkg, fgt_cell and fragment_gap_tracker_macros.svh
`default_nettype none

module fragment_gap_tracker #(
   parameter int MAX_FRAGMENTS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire fgt_pkg::req_item_type   req_item,
   output logic                         rsp_strobe,
   output fgt_pkg::rsp_item_type        rsp_item
);

   localparam int CountBits = $clog2(MAX_FRAGMENTS + 1);
   localparam int WideBits  = (CountBits > fgt_pkg::CountBits) ? CountBits
                                                              : fgt_pkg::CountBits;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [CountBits-1:0]       count_ff;
   logic [CountBits-1:0]       count_in;
   fgt_pkg::req_item_type      req_ff;
   fgt_pkg::req_item_type      req_in;
   fgt_pkg::rsp_item_type      rsp_ff;
   fgt_pkg::rsp_item_type      rsp_in;
   logic                       strobe_ff;
   logic                       strobe_in;

   fgt_pkg::cmd_type           cmd;
   fgt_pkg::link_type          link [MAX_FRAGMENTS+1];
   fgt_pkg::flag_type          flag [MAX_FRAGMENTS];
   logic [MAX_FRAGMENTS-1:0]   gap_hit_vec;
   logic [MAX_FRAGMENTS-1:0]   tile_bad_vec;
   logic                       full;
   logic                       empty;
   logic                       complete;
   logic                       requires;
   logic [WideBits-1:0]        count_wide;

   assign full  = count_ff >= CountBits'(MAX_FRAGMENTS);
   assign empty = count_ff == '0;

   assign cmd.insert      = (state_ff == ST_EXEC) &&
                            (req_ff.opcode == fgt_pkg::OP_INSERT) && !full;
   assign cmd.offset      = req_ff.frag_offset;
   assign cmd.end_pos     = {1'b0, req_ff.frag_offset} + {1'b0, req_ff.frag_length};
   assign cmd.total       = {1'b0, req_ff.total_length};
   assign cmd.query_start = {1'b0, req_ff.query_start};
   assign cmd.query_end   = {1'b0, req_ff.query_end};

   assign link[0] = '0;

   for (genvar i = 0; i < MAX_FRAGMENTS; i++) begin : g_cell
      fgt_cell #(
         .Index     (i),
         .CountBits (CountBits)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .count    (count_ff),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .flag     (flag[i])
      );
      assign gap_hit_vec[i]  = flag[i].gap_hit;
      assign tile_bad_vec[i] = flag[i].tile_bad;
   end

   assign complete = empty ? (req_ff.total_length == '0) : !(|tile_bad_vec);
   assign requires = empty ?
      (fgt_pkg::strictly_between('0, cmd.query_start, cmd.total) ||
       fgt_pkg::strictly_between('0, cmd.query_end, cmd.total)) :
      (|gap_hit_vec);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_in.answer = 1'b0;
            rsp_in.status = 1'b0;
            unique case (req_ff.opcode)
               fgt_pkg::OP_INSERT: begin
                  if (full) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               fgt_pkg::OP_COMPLETE: begin
                  rsp_in.answer = complete;
               end
               fgt_pkg::OP_REQUIRES: begin
                  rsp_in.answer = requires;
               end
               fgt_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      count_wide         = WideBits'(count_in);
      rsp_in.entry_count = count_wide[fgt_pkg::CountBits-1:0];
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == ST_EXEC) || reset;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`include "fragment_gap_tracker_macros.svh"

   `FGT_ASSERT_NEXT(a_accept_to_exec, start && !busy, busy, "accepted item not executed")
   `FGT_ASSERT_NEXT(a_exec_to_result, busy, rsp_strobe && !busy, "execute gave no result")
   `FGT_ASSERT_NOW(a_drop_only_full, rsp_strobe && rsp_item.status, full, "drop while not full")
   `FGT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CountBits'(MAX_FRAGMENTS), "count overflow")

endmodule

`default_nettype wire

// ===== hdl/fgt_cell.sv =====
// one slot of the sorted fragment row: holds offset and end of one fragment
// depends on fgt_pkg
`default_nettype none

module fgt_cell #(
   parameter int Index     = 0,
   parameter int CountBits = 5
) (
   input  wire logic                   clock,
   input  wire fgt_pkg::cmd_type       cmd,
   input  wire logic [CountBits-1:0]   count,
   input  wire fgt_pkg::link_type      link_in,
   output fgt_pkg::link_type           link_out,
   output fgt_pkg::flag_type           flag
);

   logic [fgt_pkg::OffsetBits-1:0] offset_ff;
   logic [fgt_pkg::OffsetBits-1:0] offset_in;
   logic [fgt_pkg::EndBits-1:0]    end_ff;
   logic [fgt_pkg::EndBits-1:0]    end_in;
   logic                           occupied;
   logic                           at_fill;
   logic                           last;
   logic                           gt;
   logic [fgt_pkg::EndBits-1:0]    offset_wide;
   logic [fgt_pkg::EndBits-1:0]    prev_end;

   assign occupied    = CountBits'(Index) < count;
   assign at_fill     = CountBits'(Index) == count;
   assign last        = CountBits'(Index + 1) == count;
   assign gt          = occupied && (offset_ff > cmd.offset);
   assign offset_wide = {1'b0, offset_ff};
   assign prev_end    = link_in.end_pos;

   always_comb begin
      offset_in = offset_ff;
      end_in    = end_ff;
      priority if (cmd.insert && link_in.gt) begin
         offset_in = link_in.offset;
         end_in    = link_in.end_pos;
      end else if (cmd.insert && (gt || at_fill)) begin
         offset_in = cmd.offset;
         end_in    = cmd.end_pos;
      end else begin
         offset_in = offset_ff;
         end_in    = end_ff;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      end_ff    <= end_in;
   end

   assign link_out.gt      = gt;
   assign link_out.offset  = offset_ff;
   assign link_out.end_pos = end_ff;

   // gap before this fragment, and the tail gap up to total when last
   assign flag.gap_hit =
      (occupied &&
       (fgt_pkg::strictly_between(prev_end, cmd.query_start, offset_wide) ||
        fgt_pkg::strictly_between(prev_end, cmd.query_end, offset_wide))) ||
      (last &&
       (fgt_pkg::strictly_between(end_ff, cmd.query_start, cmd.total) ||
        fgt_pkg::strictly_between(end_ff, cmd.query_end, cmd.total)));

   assign flag.tile_bad = (occupied && (offset_wide != prev_end)) ||
                          (last && (end_ff != cmd.total));

endmodule

`default_nettype wire
